FILE: hw/rtl/name_cache_ttl_round_robin_defines.svh
// Assertion macros used by the cache engine RTL.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef NAME_CACHE_TTL_ROUND_ROBIN_DEFINES_SVH
`define NAME_CACHE_TTL_ROUND_ROBIN_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define NC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nc assertion failed");

`define NC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nc assertion failed");

`else

`define NC_ASSERT_IMP(label, ante, cons)
`define NC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/nc_pkg.sv
package nc_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int KEY_WORDS_DEF = 4;
    localparam int MAX_KEY_WORDS = 4;
    localparam int WORD_W        = 64;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INSERT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [31:0] new_address;
        logic [31:0] new_lifetime;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_address;
    } rsp_t;

endpackage

FILE: hw/rtl/name_cache_ttl_round_robin.sv
// Channel | Dir | Handshake            | Beat
// req     | in  | req_valid/req_ready  | nc_pkg::req_t  (cmd, key words, address, lifetime)
// rsp     | out | rsp_valid/rsp_ready  | nc_pkg::rsp_t  (hit, found_address), lookups only
//
// One request at a time; the slot memories are scanned one slot per cycle.
// Lookup or insert: the scan ends at the first matching slot or at the last slot.
// A lookup then passes through ST_RESULT; an insert miss writes the pointer slot in ST_WRITE.
// Tick: ages each valid slot with a nonzero lifetime by read, decrement, write back.
// Reset clears valid bits and the replace pointer at once; no clearing pass.
// A lookup result parks in the output register; the engine stalls only when it is still full.
module name_cache_ttl_round_robin #(
    parameter int ENTRIES   = nc_pkg::ENTRIES_DEF,
    parameter int KEY_WORDS = nc_pkg::KEY_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  nc_pkg::req_t  req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output nc_pkg::rsp_t  rsp
);

    logic          res_valid;
    logic          res_ready;
    nc_pkg::rsp_t  res;

    logic          rsp_valid_reg, rsp_valid_next;
    nc_pkg::rsp_t  rsp_reg, rsp_next;

    nc_engine #(.ENTRIES(ENTRIES), .KEY_WORDS(KEY_WORDS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result when the output register is empty or draining this cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hw/rtl/nc_ram.sv
module nc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/nc_engine.sv
`include "name_cache_ttl_round_robin_defines.svh"

module nc_engine #(
    parameter int ENTRIES   = nc_pkg::ENTRIES_DEF,
    parameter int KEY_WORDS = nc_pkg::KEY_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  nc_pkg::req_t  req,
    output logic          res_valid,
    input  logic          res_ready,
    output nc_pkg::rsp_t  res
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int KEY_W  = KEY_WORDS * nc_pkg::WORD_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_TICK   = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    nc_pkg::req_t        item_reg, item_next;
    logic                issue_active_reg, issue_active_next;
    logic [SLOT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    nc_pkg::rsp_t        res_reg, res_next;

    logic [nc_pkg::MAX_KEY_WORDS*nc_pkg::WORD_W-1:0] key_full;
    logic [KEY_W-1:0]    item_key;
    logic [KEY_W-1:0]    key_rdata;
    logic [63:0]         data_rdata;
    logic [31:0]         addr_rdata;
    logic [31:0]         life_rdata;
    logic [31:0]         life_dec;
    logic                life_tick_we;
    logic                data_we;
    logic [SLOT_W-1:0]   data_waddr;
    logic [63:0]         data_wdata;
    logic                write_slot;
    logic                slot_match;
    logic                pend_last;

    assign key_full = {item_reg.key_word3, item_reg.key_word2,
                       item_reg.key_word1, item_reg.key_word0};
    assign item_key = key_full[KEY_W-1:0];

    assign write_slot = (state_reg == ST_WRITE);
    assign addr_rdata = data_rdata[63:32];
    assign life_rdata = data_rdata[31:0];
    assign life_dec   = life_rdata - 32'd1;
    assign data_we    = write_slot || life_tick_we;
    assign data_waddr = write_slot ? ptr_reg : pend_idx_reg;
    // an aging write carries back the address it just read
    assign data_wdata = write_slot ? {item_reg.new_address, item_reg.new_lifetime}
                                   : {addr_rdata, life_dec};

    nc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk     (clk),
        .wr_en   (write_slot),
        .wr_addr (ptr_reg),
        .wr_data (item_key),
        .rd_addr (issue_idx_reg),
        .rd_data (key_rdata)
    );

    nc_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (data_waddr),
        .wr_data (data_wdata),
        .rd_addr (issue_idx_reg),
        .rd_data (data_rdata)
    );

    // Read data lines up with pend_idx_reg, arriving the cycle after its address is issued.
    assign slot_match = valid_reg[pend_idx_reg] && (key_rdata == item_key);
    assign pend_last  = (pend_idx_reg == LAST_SLOT);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        issue_active_next = issue_active_reg;
        issue_idx_next    = issue_idx_reg;
        pend_valid_next   = 1'b0;
        pend_idx_next     = issue_idx_reg;
        valid_next        = valid_reg;
        ptr_next          = ptr_reg;
        res_next          = res_reg;
        life_tick_we      = 1'b0;

        if ((state_reg == ST_SCAN || state_reg == ST_TICK) && issue_active_reg)
        begin
            pend_valid_next = 1'b1;
            if (issue_idx_reg == LAST_SLOT)
            begin
                issue_active_next = 1'b0;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next      = req;
                    issue_idx_next = '0;
                    case (req.cmd)
                        nc_pkg::CMD_TICK:
                        begin
                            issue_active_next = 1'b1;
                            state_next        = ST_TICK;
                        end
                        nc_pkg::CMD_LOOKUP, nc_pkg::CMD_INSERT:
                        begin
                            issue_active_next = 1'b1;
                            state_next        = ST_SCAN;
                        end
                        default:
                        begin
                            // drop the unused command
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_valid_reg && (slot_match || pend_last))
                begin
                    issue_active_next = 1'b0;
                    pend_valid_next   = 1'b0;
                    if (item_reg.cmd == nc_pkg::CMD_LOOKUP)
                    begin
                        res_next.hit           = slot_match;
                        res_next.found_address = slot_match ? addr_rdata : 32'd0;
                        state_next             = ST_RESULT;
                    end
                    else if (slot_match)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_TICK:
            begin
                if (pend_valid_reg)
                begin
                    if (valid_reg[pend_idx_reg] && life_rdata != 32'd0)
                    begin
                        life_tick_we = 1'b1;
                        if (life_dec == 32'd0)
                        begin
                            valid_next[pend_idx_reg] = 1'b0;
                        end
                    end
                    if (pend_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WRITE:
            begin
                valid_next[ptr_reg] = 1'b1;
                ptr_next            = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
                state_next          = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_active_reg <= 1'b0;
            issue_idx_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_idx_reg     <= '0;
            valid_reg        <= '0;
            ptr_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_active_reg <= issue_active_next;
            issue_idx_reg    <= issue_idx_next;
            pend_valid_reg   <= pend_valid_next;
            pend_idx_reg     <= pend_idx_next;
            valid_reg        <= valid_next;
            ptr_reg          <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    `NC_ASSERT_NEXT(a_search_starts, req_valid && req_ready && (req.cmd == nc_pkg::CMD_LOOKUP || req.cmd == nc_pkg::CMD_INSERT), state_reg == ST_SCAN)
    `NC_ASSERT_NEXT(a_write_sets_valid, state_reg == ST_WRITE, valid_reg[$past(ptr_reg)])
    `NC_ASSERT_IMP(a_ptr_range, 1'b1, 32'(ptr_reg) < ENTRIES)
    `NC_ASSERT_IMP(a_pipe_order, pend_valid_reg && issue_active_reg, issue_idx_reg == pend_idx_reg + 1'b1)
    `NC_ASSERT_NEXT(a_ptr_moves_on_write, state_reg != ST_WRITE, $stable(ptr_reg))

endmodule
